// ===== rtl/core/rgb2hsv_pkg.sv =====
// shared types for the rgb to hsv pixel converter
package rgb2hsv_pkg;

  // which channel holds the maximum, in the order the hue sectors are taken
  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // per-item sideband that rides along the divider stages
  typedef struct packed {
    sector_e    sector;
    logic       negative;
    logic       defined;
    logic [7:0] value;
    logic [7:0] delta;
  } side_t;

  localparam int unsigned HueOutW = 15;
  localparam int unsigned SatOutW = 13;

endpackage

// ===== rtl/core/rgb_to_hsv_pixel.sv =====
// rgb to hsv pixel converter, fully pipelined with two radix-2 divider lanes
//
//   channel  direction  handshake              fields
//   input    in         start high, busy low   red_i, green_i, blue_i
//   result   out        result_valid_o strobe  hue_o, hue_defined_o, saturation_o, brightness_o
//
// one item may enter every cycle; busy is held low
// each item runs through stage 1, stage 2, the divider load register, the divider stages and
// the output register; the restoring divider takes two quotient bits per stage over the widest dividend
// reset clears every valid bit at once, payload registers are not reset
// each result shows for one cycle only; the receiver cannot hold it off
module rgb_to_hsv_pixel
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                result_valid_o,
  output logic [HueOutW-1:0]  hue_o,
  output logic                hue_defined_o,
  output logic [SatOutW-1:0]  saturation_o,
  output logic [7:0]          brightness_o
);

  localparam int unsigned HueSector = 60 << HUE_FRAC_BITS;
  localparam int unsigned HueFull   = 360 << HUE_FRAC_BITS;
  localparam int unsigned HueProdW  = 14 + HUE_FRAC_BITS;
  localparam int unsigned SatDivW   = 8 + SAT_FRAC_BITS;
  localparam int unsigned DivW0     = (HueProdW > SatDivW) ? HueProdW : SatDivW;
  localparam int unsigned Nst       = (DivW0 + 1) / 2;
  localparam int unsigned DivW      = 2 * Nst;
  localparam int unsigned AccW      = 8 + DivW;
  localparam int unsigned HueW      = $clog2(HueFull + 1);
  localparam int unsigned HueX      = (HueW > HueOutW) ? HueW : HueOutW;
  localparam int unsigned FracW     = $clog2(HueSector + 1);

  localparam logic [HueProdW-1:0] HueSectorC = HueProdW'(HueSector);
  localparam logic signed [HueX:0] HueFullC  = (HueX+1)'(HueFull);
  localparam logic signed [HueX:0] Base2C    = (HueX+1)'(2 * HueSector);
  localparam logic signed [HueX:0] Base4C    = (HueX+1)'(4 * HueSector);

  // one restoring step: remainder in the top byte, dividend shifts out as quotient shifts in
  function automatic logic [AccW-1:0] div_step(input logic [AccW-1:0] acc,
                                               input logic [7:0] dsr);
    logic [8:0] trial;
    logic [8:0] diff;
    logic [AccW-1:0] res;
    trial = {acc[AccW-1:DivW], acc[DivW-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      res = {diff[7:0], acc[DivW-2:0], 1'b1};
    end else begin
      res = {trial[7:0], acc[DivW-2:0], 1'b0};
    end
    return res;
  endfunction

  assign busy = 1'b0;

  // stage 1: max and min
  logic       s1_v_q;
  logic [7:0] s1_r_q, s1_g_q, s1_b_q, s1_mx_q, s1_mn_q;
  logic [7:0] s1_mx_d, s1_mn_d, rg_max, rg_min;

  always_comb begin
    rg_max  = (red_i > green_i) ? red_i : green_i;
    rg_min  = (red_i > green_i) ? green_i : red_i;
    s1_mx_d = (rg_max > blue_i) ? rg_max : blue_i;
    s1_mn_d = (rg_min < blue_i) ? rg_min : blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q  <= red_i;
    s1_g_q  <= green_i;
    s1_b_q  <= blue_i;
    s1_mx_q <= s1_mx_d;
    s1_mn_q <= s1_mn_d;
  end

  // stage 2: sector, signed difference and delta
  logic       s2_v_q;
  side_t      s2_side_q, s2_side_d;
  logic [7:0] s2_mag_q, s2_mag_d;
  logic [7:0] pos, neg;

  always_comb begin
    s2_side_d.value   = s1_mx_q;
    s2_side_d.delta   = s1_mx_q - s1_mn_q;
    s2_side_d.defined = (s1_mx_q != s1_mn_q);
    priority if (s1_r_q == s1_mx_q) begin
      s2_side_d.sector = SECT_RED;
      pos = s1_g_q;
      neg = s1_b_q;
    end else if (s1_g_q == s1_mx_q) begin
      s2_side_d.sector = SECT_GREEN;
      pos = s1_b_q;
      neg = s1_r_q;
    end else begin
      s2_side_d.sector = SECT_BLUE;
      pos = s1_r_q;
      neg = s1_g_q;
    end
    s2_side_d.negative = (neg > pos);
    s2_mag_d = s2_side_d.negative ? (neg - pos) : (pos - neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_side_q <= s2_side_d;
    s2_mag_q  <= s2_mag_d;
  end

  // divider lanes: hue fraction over delta, saturation over max
  logic            dv_v_q    [Nst+1];
  side_t           dv_side_q [Nst+1];
  logic [AccW-1:0] acc_h_q   [Nst+1];
  logic [AccW-1:0] acc_s_q   [Nst+1];
  logic [HueProdW-1:0] hue_prod;

  assign hue_prod = HueProdW'(s2_mag_q) * HueSectorC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_side_q[0] <= s2_side_q;
    acc_h_q[0]   <= {8'd0, DivW'(hue_prod)};
    acc_s_q[0]   <= {8'd0, DivW'({s2_side_q.delta, {SAT_FRAC_BITS{1'b0}}})};
  end

  for (genvar k = 0; k < Nst; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_side_q[k+1] <= dv_side_q[k];
      acc_h_q[k+1]   <= div_step(div_step(acc_h_q[k], dv_side_q[k].delta),
                                 dv_side_q[k].delta);
      acc_s_q[k+1]   <= div_step(div_step(acc_s_q[k], dv_side_q[k].value),
                                 dv_side_q[k].value);
    end
  end

  // output stage: place the fraction in its sector, wrap negatives and zero hue and saturation for gray
  side_t                fin_side;
  logic [FracW-1:0]     frac;
  logic signed [HueX:0] base, hue_sum, hue_wrap;
  logic                 out_v_q;
  logic [HueOutW-1:0]   hue_q, hue_d;
  logic                 def_q;
  logic [SatOutW-1:0]   sat_q, sat_d;
  logic [7:0]           val_q;

  always_comb begin
    fin_side = dv_side_q[Nst];
    frac     = acc_h_q[Nst][FracW-1:0];
    unique case (fin_side.sector)
      SECT_RED:   base = '0;
      SECT_GREEN: base = Base2C;
      SECT_BLUE:  base = Base4C;
      default:    base = '0;
    endcase
    hue_sum  = fin_side.negative ? (base - (HueX+1)'(frac)) : (base + (HueX+1)'(frac));
    hue_wrap = hue_sum[HueX] ? (hue_sum + HueFullC) : hue_sum;
    hue_d    = fin_side.defined ? hue_wrap[HueOutW-1:0] : '0;
    sat_d    = fin_side.defined ? acc_s_q[Nst][SatOutW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v_q[Nst];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q <= hue_d;
    def_q <= fin_side.defined;
    sat_q <= sat_d;
    val_q <= fin_side.value;
  end

  assign result_valid_o = out_v_q;
  assign hue_o          = hue_q;
  assign hue_defined_o  = def_q;
  assign saturation_o   = sat_q;
  assign brightness_o   = val_q;

endmodule

// ===== rtl/core/rgb2hsv_chk.sv =====
// port-level checks for the rgb to hsv pixel converter, bound to the top level
module rgb2hsv_chk
  import rgb2hsv_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 12
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [HueOutW-1:0] hue_o,
  input logic               hue_defined_o,
  input logic [SatOutW-1:0] saturation_o,
  input logic [7:0]         brightness_o
);

  localparam int unsigned HueFull  = 360 << HUE_FRAC_BITS;
  localparam int unsigned HueProdW = 14 + HUE_FRAC_BITS;
  localparam int unsigned SatDivW  = 8 + SAT_FRAC_BITS;
  localparam int unsigned DivW0    = (HueProdW > SatDivW) ? HueProdW : SatDivW;
  localparam int unsigned Latency  = 4 + (DivW0 + 1) / 2;
  localparam bit          HueFits  = (HueFull <= (1 << HueOutW));

  // every accepted item comes out exactly after the pipeline latency
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency result_valid_o)
    else $error("accepted item did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !result_valid_o)
    else $error("result strobe without an accepted item");

  // gray or black gives zero hue and zero saturation
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !hue_defined_o) |-> (hue_o == '0 && saturation_o == '0))
    else $error("undefined hue with nonzero hue or saturation");

  // a defined hue needs a nonzero max, and hue stays below a full turn where a full turn fits the hue port
  a_defined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hue_defined_o) |->
      (brightness_o != 8'd0 && (!HueFits || 32'(hue_o) < HueFull)))
    else $error("defined hue with zero brightness or hue out of range");

endmodule

bind rgb_to_hsv_pixel rgb2hsv_chk #(
  .HUE_FRAC_BITS(HUE_FRAC_BITS),
  .SAT_FRAC_BITS(SAT_FRAC_BITS)
) u_rgb2hsv_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .hue_o          (hue_o),
  .hue_defined_o  (hue_defined_o),
  .saturation_o   (saturation_o),
  .brightness_o   (brightness_o)
);

// ===== bench/tb_rgb_to_hsv_pixel.sv =====
// testbench for the rgb to hsv pixel converter: directed table, random pixels, self-checking
module tb_rgb_to_hsv_pixel;
  import rgb2hsv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HUE_FRAC    = 6;
  localparam int unsigned SAT_FRAC    = 12;
  localparam int unsigned HUE_SECTOR  = 60 << HUE_FRAC;
  localparam int unsigned HUE_FULL    = 360 << HUE_FRAC;
  localparam int unsigned LATENCY     = 14;
  localparam int unsigned N_RANDOM    = 1000;
  localparam int unsigned N_QUIET     = 150;
  localparam int unsigned CYCLE_LIMIT = 60000;
  localparam int unsigned N_DIRECTED  = 20;
  localparam int unsigned PRINT_CAP   = 40;

  typedef struct {
    logic [HueOutW-1:0] hue;
    logic               hue_ok;
    logic [SatOutW-1:0] sat;
    logic [7:0]         value;
  } pixel_hsv_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    bit         typed;
    pixel_hsv_t want;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [7:0] red_i, green_i, blue_i;
  logic result_valid_o;
  logic [HueOutW-1:0] hue_o;
  logic hue_defined_o;
  logic [SatOutW-1:0] saturation_o;
  logic [7:0] brightness_o;

  pixel_hsv_t hsv_due_q[$];
  int unsigned n_pixels_sent  = 0;
  int unsigned n_results_seen = 0;
  int unsigned n_errors       = 0;
  int unsigned cycle_cnt      = 0;

  logic [7:0] corner_vals [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

  // rows with typed results can be read straight off the conversion rules
  pixel_row_t pixel_table [N_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     1'b0, 13'd0,    8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     1'b0, 13'd0,    8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     1'b0, 13'd0,    8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     1'b1, 13'd4096, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  1'b1, 13'd4096, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 1'b1, 13'd4096, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  1'b1, 13'd4096, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 1'b1, 13'd4096, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 1'b1, 13'd4096, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     1'b1, 13'd4096, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd255, 8'd254, 8'd254, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd0,   8'd1,   8'd0,   1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd254, 8'd255, 8'd253, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd128, 8'd127, 8'd129, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd85,  8'd170, 8'd255, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd170, 8'd85,  8'd170, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd100, 8'd50,  8'd200, 1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}},
    '{8'd12,  8'd200, 8'd77,  1'b0, '{15'd0,     1'b0, 13'd0,    8'd0}}
  };

  rgb_to_hsv_pixel DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .result_valid_o (result_valid_o),
    .hue_o          (hue_o),
    .hue_defined_o  (hue_defined_o),
    .saturation_o   (saturation_o),
    .brightness_o   (brightness_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic pixel_hsv_t hsv_of_pixel(input logic [7:0] r, g, b);
    logic [7:0] vmax, vmin, delta, pos, neg, mag;
    sector_e sect;
    logic negative;
    int unsigned frac, base, hue, sat;
    pixel_hsv_t res;
    if (r > g && r > b) begin
      vmax = r;
      vmin = (g < b) ? g : b;
    end else if (g > b) begin
      vmax = g;
      vmin = (r < b) ? r : b;
    end else begin
      vmax = b;
      vmin = (r < g) ? r : g;
    end
    delta = vmax - vmin;
    res = '{hue: '0, hue_ok: 1'b0, sat: '0, value: vmax};
    if (delta != 0) begin
      sat = (32'(delta) << SAT_FRAC) / 32'(vmax);
      // ties go to red first, then green, when picking the sector
      if (r == vmax) begin
        sect = SECT_RED;
        pos = g;
        neg = b;
      end else if (g == vmax) begin
        sect = SECT_GREEN;
        pos = b;
        neg = r;
      end else begin
        sect = SECT_BLUE;
        pos = r;
        neg = g;
      end
      negative = neg > pos;
      mag = negative ? neg - pos : pos - neg;
      frac = (HUE_SECTOR * 32'(mag)) / 32'(delta);
      base = 2 * HUE_SECTOR * int'(sect);
      if (!negative) hue = base + frac;
      else if (frac > base) hue = HUE_FULL - (frac - base);
      else hue = base - frac;
      res.hue_ok = 1'b1;
      res.hue = hue[HueOutW-1:0];
      res.sat = sat[SatOutW-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  // one item per call; start stays high into the next call unless a gap follows
  task automatic drive_pixel(input logic [7:0] r, g, b, input pixel_hsv_t want,
                             input bit allow_gap);
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    hsv_due_q.push_back(want);
    n_pixels_sent++;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (hsv_due_q.size() != 0);
  endtask

  always @(posedge clk_i) begin : check_results
    pixel_hsv_t want;
    if (rst_ni && result_valid_o) begin
      n_results_seen++;
      if (hsv_due_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = hsv_due_q.pop_front();
        if (hue_o !== want.hue)
          report_mismatch($sformatf("hue %0d, want %0d", hue_o, want.hue));
        if (hue_defined_o !== want.hue_ok)
          report_mismatch($sformatf("hue_defined %0b, want %0b", hue_defined_o, want.hue_ok));
        if (saturation_o !== want.sat)
          report_mismatch($sformatf("saturation %0d, want %0d", saturation_o, want.sat));
        if (brightness_o !== want.value)
          report_mismatch($sformatf("brightness %0d, want %0d", brightness_o, want.value));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               hsv_due_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] r, g, b, seed_val;
    pixel_hsv_t want;
    start = 1'b0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[i]) begin
      want = pixel_table[i].typed ? pixel_table[i].want
           : hsv_of_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
      drive_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b, want, 1'b1);
    end
    hold_until_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = r;
            default: b = g;
          endcase
        end
        2: begin
          r = corner_vals[$urandom_range(0, 3)];
          g = corner_vals[$urandom_range(0, 3)];
          b = corner_vals[$urandom_range(0, 3)];
        end
        3: begin
          // near-gray pixels give tiny deltas
          seed_val = 8'($urandom_range(0, 255));
          r = seed_val ^ 8'($urandom_range(0, 3));
          g = seed_val ^ 8'($urandom_range(0, 3));
          b = seed_val ^ 8'($urandom_range(0, 3));
        end
        default: ;
      endcase
      drive_pixel(r, g, b, hsv_of_pixel(r, g, b), i < N_RANDOM - N_QUIET);
      if (i == N_RANDOM / 2) hold_until_drained();
    end

    start <= 1'b0;
    do @(posedge clk_i); while (hsv_due_q.size() != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
    foreach (hsv_due_q[i]) report_mismatch("expected result never arrived");

    $display("sent %0d pixels (%0d from the table, %0d random), checked %0d results",
             n_pixels_sent, N_DIRECTED, N_RANDOM, n_results_seen);
    $display("grays, ties, corner values, near-grays and hue wrap-around covered, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
